FILE: hw/rtl/xdr_pkg.sv
package xdr_pkg;

    localparam int FRAME_WORDS    = 1024;
    localparam int WORD_AW        = $clog2(FRAME_WORDS);
    localparam int SCAN_W         = WORD_AW + 1;
    localparam int LEN_W          = SCAN_W;

    localparam int REC_AW         = 6;
    localparam int HISTORY_FRAMES = 1 << REC_AW;
    localparam int CNT_W          = REC_AW + 1;

    localparam int PAIR_AW        = 13;
    localparam int PAIR_DEPTH     = 1 << PAIR_AW;
    localparam int USED_W         = PAIR_AW + 1;

    typedef enum logic [2:0] {
        ACT_WRITE   = 3'd0,
        ACT_SUBMIT  = 3'd1,
        ACT_REWIND  = 3'd2,
        ACT_ADVANCE = 3'd3,
        ACT_READ    = 3'd4,
        ACT_LIMIT   = 3'd5,
        ACT_CLEAR   = 3'd6,
        ACT_NONE    = 3'd7
    } action_t;

    typedef struct packed {
        action_t       action;
        logic [9:0]    word_index;
        logic [31:0]   word_value;
        logic [31:0]   disc_id;
        logic [63:0]   counter_value;
        logic          auto_counter;
        logic [15:0]   frame_count;
    } item_t;

    typedef struct packed {
        logic [31:0]   read_value;
        logic [6:0]    frames_moved;
        logic [63:0]   current_counter;
        logic [31:0]   current_disc;
        logic [6:0]    past_count;
        logic [6:0]    future_count;
        logic          has_current;
    } result_t;

    typedef struct packed {
        logic [63:0]        before_ctr;
        logic [63:0]        after_ctr;
        logic [31:0]        before_disc;
        logic [31:0]        after_disc;
        logic [PAIR_AW-1:0] start;
        logic [LEN_W-1:0]   len;
    } rec_t;

    typedef struct packed {
        logic [WORD_AW-1:0] idx;
        logic [31:0]        val;
    } pair_t;

endpackage

FILE: hw/rtl/xdr_ram.sv
module xdr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hw/rtl/xor_delta_rewind_history_unit.sv
// channel   direction   handshake                    payload
// item      in          item_valid / item_ready      item_t
// result    out         result_valid / result_ready  result_t
//
// one transaction at a time; a result always follows each item
// the result leaves from an output register
// submit: two passes over the frame banks (one read port each),
// plus a record read and an update per dropped future or culled past record
// rewind/advance: per frame a record read, then pair read, frame read and xor write back
// no clearing pass after reset; a stalled result holds the next one in the done state
module xor_delta_rewind_history_unit
    import xdr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    typedef enum logic [13:0] {
        S_IDLE      = 14'b00000000000001,
        S_RDW       = 14'b00000000000010,
        S_NEXT      = 14'b00000000000100,
        S_DROP_RD   = 14'b00000000001000,
        S_DROP_UPD  = 14'b00000000010000,
        S_CULL_RD   = 14'b00000000100000,
        S_CULL_UPD  = 14'b00000001000000,
        S_SCAN      = 14'b00000010000000,
        S_REC_WR    = 14'b00000100000000,
        S_SWAP      = 14'b00001000000000,
        S_MOVE_RD   = 14'b00010000000000,
        S_MOVE_META = 14'b00100000000000,
        S_APPLY     = 14'b01000000000000,
        S_DONE      = 14'b10000000000000
    } state_t;

    typedef enum logic [2:0] {
        P_DROP  = 3'd0,
        P_COUNT = 3'd1,
        P_FIT   = 3'd2,
        P_WRITE = 3'd3,
        P_FINAL = 3'd4,
        P_END   = 3'd5,
        P_LIMP  = 3'd6,
        P_LIMF  = 3'd7
    } phase_t;

    state_t              state_reg, state_next;
    action_t             op_reg, op_next;
    phase_t              phase_reg, phase_next;
    logic [15:0]         cnt_in_reg, cnt_in_next;
    logic [63:0]         ctr_in_reg, ctr_in_next;
    logic [31:0]         disc_in_reg, disc_in_next;
    logic                sel_reg, sel_next;
    logic                have_reg, have_next;
    logic [63:0]         cur_ctr_reg, cur_ctr_next;
    logic [31:0]         cur_disc_reg, cur_disc_next;
    logic [REC_AW-1:0]   oldest_reg, oldest_next;
    logic [CNT_W-1:0]    past_reg, past_next;
    logic [CNT_W-1:0]    fut_reg, fut_next;
    logic [PAIR_AW-1:0]  head_reg, head_next;
    logic [USED_W-1:0]   used_reg, used_next;
    logic [CNT_W-1:0]    limit_reg, limit_next;
    logic [LEN_W-1:0]    n_reg, n_next;
    logic [SCAN_W-1:0]   scan_addr_reg, scan_addr_next;
    logic                scan_v_reg, scan_v_next;
    logic [WORD_AW-1:0]  scan_idx_reg, scan_idx_next;
    logic [PAIR_AW-1:0]  wptr_reg, wptr_next;
    logic [CNT_W-1:0]    moved_reg, moved_next;
    logic [31:0]         rd_reg, rd_next;
    logic [CNT_W-1:0]    pr_reg, pr_next;
    logic [CNT_W:0]      rem_reg, rem_next;
    logic [CNT_W-1:0]    m_reg, m_next;
    rec_t                meta_reg, meta_next;
    logic [LEN_W-1:0]    k_reg, k_next;
    logic                v1_reg, v1_next;
    logic                v2_reg, v2_next;
    logic [WORD_AW-1:0]  idx2_reg, idx2_next;
    logic [31:0]         val2_reg, val2_next;
    result_t             out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    logic                b_re;
    logic [WORD_AW-1:0]  b_raddr;
    logic                b_we0, b_we1;
    logic [WORD_AW-1:0]  b_waddr;
    logic [31:0]         b_wdata;
    logic [31:0]         b0_rdata, b1_rdata, cur_rdata;

    logic                rec_we, rec_re;
    logic [REC_AW-1:0]   rec_waddr, rec_raddr;
    rec_t                rec_wdata, rec_rdata;

    logic                p_we, p_re;
    logic [PAIR_AW-1:0]  p_waddr, p_raddr;
    pair_t               p_wdata, p_rdata;

    logic                accept;
    logic [USED_W-1:0]   free_w;
    logic [CNT_W-1:0]    lim_m;
    logic [CNT_W:0]      lim_total, lim_keep, lim_remove;
    logic [CNT_W-1:0]    lim_pr;
    logic [31:0]         scan_x;
    logic                scan_issue, apply_issue;

    xdr_ram #(.WIDTH(32), .DEPTH(FRAME_WORDS)) u_bank0 (
        .clk(clk), .we(b_we0), .waddr(b_waddr), .wdata(b_wdata),
        .re(b_re), .raddr(b_raddr), .rdata(b0_rdata)
    );

    xdr_ram #(.WIDTH(32), .DEPTH(FRAME_WORDS)) u_bank1 (
        .clk(clk), .we(b_we1), .waddr(b_waddr), .wdata(b_wdata),
        .re(b_re), .raddr(b_raddr), .rdata(b1_rdata)
    );

    xdr_ram #(.WIDTH($bits(rec_t)), .DEPTH(HISTORY_FRAMES)) u_rec (
        .clk(clk), .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
        .re(rec_re), .raddr(rec_raddr), .rdata(rec_rdata)
    );

    xdr_ram #(.WIDTH($bits(pair_t)), .DEPTH(PAIR_DEPTH)) u_pair (
        .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .re(p_re), .raddr(p_raddr), .rdata(p_rdata)
    );

    assign item_ready   = (state_reg == S_IDLE);
    assign accept       = item_valid && item_ready;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign cur_rdata    = sel_reg ? b1_rdata : b0_rdata;
    assign free_w       = USED_W'(PAIR_DEPTH) - used_reg;
    assign scan_x       = b0_rdata ^ b1_rdata;
    assign scan_issue   = scan_addr_reg < SCAN_W'(FRAME_WORDS);
    assign apply_issue  = k_reg < meta_reg.len;

    // limit trimming amounts, from the state at acceptance
    assign lim_m      = (item.frame_count > 16'(HISTORY_FRAMES)) ? CNT_W'(HISTORY_FRAMES)
                                                                 : item.frame_count[CNT_W-1:0];
    assign lim_total  = {1'b0, past_reg} + {1'b0, fut_reg} + {{CNT_W{1'b0}}, have_reg};
    assign lim_keep   = ({1'b0, lim_m} < lim_total) ? {1'b0, lim_m} : lim_total;
    assign lim_remove = lim_total - lim_keep;
    assign lim_pr     = (lim_remove < {1'b0, past_reg}) ? lim_remove[CNT_W-1:0] : past_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        phase_next     = phase_reg;
        cnt_in_next    = cnt_in_reg;
        ctr_in_next    = ctr_in_reg;
        disc_in_next   = disc_in_reg;
        sel_next       = sel_reg;
        have_next      = have_reg;
        cur_ctr_next   = cur_ctr_reg;
        cur_disc_next  = cur_disc_reg;
        oldest_next    = oldest_reg;
        past_next      = past_reg;
        fut_next       = fut_reg;
        head_next      = head_reg;
        used_next      = used_reg;
        limit_next     = limit_reg;
        n_next         = n_reg;
        scan_addr_next = scan_addr_reg;
        scan_v_next    = scan_v_reg;
        scan_idx_next  = scan_idx_reg;
        wptr_next      = wptr_reg;
        moved_next     = moved_reg;
        rd_next        = rd_reg;
        pr_next        = pr_reg;
        rem_next       = rem_reg;
        m_next         = m_reg;
        meta_next      = meta_reg;
        k_next         = k_reg;
        v1_next        = v1_reg;
        v2_next        = v2_reg;
        idx2_next      = idx2_reg;
        val2_next      = val2_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        b_re      = 1'b0;
        b_raddr   = item.word_index;
        b_we0     = 1'b0;
        b_we1     = 1'b0;
        b_waddr   = item.word_index;
        b_wdata   = item.word_value;
        rec_we    = 1'b0;
        rec_waddr = REC_AW'(oldest_reg + past_reg[REC_AW-1:0]);
        rec_wdata = '{before_ctr: cur_ctr_reg, after_ctr: ctr_in_reg,
                      before_disc: cur_disc_reg, after_disc: disc_in_reg,
                      start: PAIR_AW'(head_reg + used_reg[PAIR_AW-1:0]), len: n_reg};
        rec_re    = 1'b0;
        rec_raddr = oldest_reg;
        p_we      = 1'b0;
        p_waddr   = wptr_reg;
        p_wdata   = '{idx: scan_idx_reg, val: scan_x};
        p_re      = 1'b0;
        p_raddr   = PAIR_AW'(meta_reg.start + PAIR_AW'(k_reg));

        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next      = item.action;
                    cnt_in_next  = item.frame_count;
                    disc_in_next = item.disc_id;
                    ctr_in_next  = item.auto_counter
                                   ? (have_reg ? cur_ctr_reg + 64'd1 : cur_ctr_reg)
                                   : item.counter_value;
                    rd_next      = '0;
                    moved_next   = '0;
                    state_next   = S_DONE;
                    unique case (item.action) inside
                        ACT_WRITE:
                        begin
                            // before the first submit the current bank takes the write
                            if (have_reg ^ sel_reg)
                            begin
                                b_we1 = 1'b1;
                            end
                            else
                            begin
                                b_we0 = 1'b1;
                            end
                        end
                        ACT_SUBMIT:
                        begin
                            phase_next = P_DROP;
                            state_next = S_NEXT;
                        end
                        ACT_REWIND, ACT_ADVANCE:
                        begin
                            state_next = S_NEXT;
                        end
                        ACT_READ:
                        begin
                            b_re       = 1'b1;
                            state_next = S_RDW;
                        end
                        ACT_LIMIT:
                        begin
                            if (item.frame_count == 16'd0)
                            begin
                                head_next    = '0;
                                used_next    = '0;
                                oldest_next  = '0;
                                past_next    = '0;
                                fut_next     = '0;
                                cur_ctr_next = '0;
                                cur_disc_next = '0;
                                have_next    = 1'b0;
                            end
                            else
                            begin
                                m_next     = lim_m;
                                pr_next    = lim_pr;
                                rem_next   = lim_remove - {1'b0, lim_pr};
                                phase_next = P_LIMP;
                                state_next = S_NEXT;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            head_next     = '0;
                            used_next     = '0;
                            oldest_next   = '0;
                            past_next     = '0;
                            fut_next      = '0;
                            cur_ctr_next  = '0;
                            cur_disc_next = '0;
                            have_next     = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RDW:
            begin
                rd_next    = cur_rdata;
                state_next = S_DONE;
            end
            S_NEXT:
            begin
                state_next = S_DONE;
                unique case (op_reg) inside
                    ACT_SUBMIT:
                    begin
                        if (!have_reg)
                        begin
                            have_next     = 1'b1;
                            cur_ctr_next  = ctr_in_reg;
                            cur_disc_next = disc_in_reg;
                        end
                        else if (phase_reg == P_DROP)
                        begin
                            if (fut_reg != '0)
                            begin
                                state_next = S_DROP_RD;
                            end
                            else
                            begin
                                scan_addr_next = '0;
                                scan_v_next    = 1'b0;
                                n_next         = '0;
                                phase_next     = P_COUNT;
                                state_next     = S_SCAN;
                            end
                        end
                        else if (phase_reg == P_FIT)
                        begin
                            if (past_reg != '0 &&
                                (free_w < USED_W'(n_reg) || past_reg >= CNT_W'(HISTORY_FRAMES)))
                            begin
                                state_next = S_CULL_RD;
                            end
                            else if (USED_W'(n_reg) <= free_w &&
                                     past_reg < CNT_W'(HISTORY_FRAMES))
                            begin
                                state_next = S_REC_WR;
                            end
                            else
                            begin
                                state_next = S_SWAP;
                            end
                        end
                        else if (phase_reg == P_FINAL)
                        begin
                            if (({1'b0, past_reg} + 1'b1) > {1'b0, limit_reg} && past_reg != '0)
                            begin
                                phase_next = P_END;
                                state_next = S_CULL_RD;
                            end
                        end
                    end
                    ACT_REWIND, ACT_ADVANCE:
                    begin
                        if ((16'(moved_reg) < cnt_in_reg) &&
                            ((op_reg == ACT_REWIND) ? (past_reg != '0) : (fut_reg != '0)))
                        begin
                            state_next = S_MOVE_RD;
                        end
                    end
                    ACT_LIMIT:
                    begin
                        if (phase_reg == P_LIMP && pr_reg != '0)
                        begin
                            pr_next    = pr_reg - 1'b1;
                            state_next = S_CULL_RD;
                        end
                        else if (rem_reg != '0 && fut_reg != '0)
                        begin
                            phase_next = P_LIMF;
                            rem_next   = rem_reg - 1'b1;
                            state_next = S_DROP_RD;
                        end
                        else
                        begin
                            limit_next = m_reg;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_DROP_RD:
            begin
                rec_re     = 1'b1;
                rec_raddr  = REC_AW'(oldest_reg + past_reg[REC_AW-1:0]
                                     + fut_reg[REC_AW-1:0] - 1'b1);
                state_next = S_DROP_UPD;
            end
            S_DROP_UPD:
            begin
                used_next  = used_reg - USED_W'(rec_rdata.len);
                fut_next   = fut_reg - 1'b1;
                state_next = S_NEXT;
            end
            S_CULL_RD:
            begin
                rec_re     = 1'b1;
                state_next = S_CULL_UPD;
            end
            S_CULL_UPD:
            begin
                head_next   = PAIR_AW'(head_reg + PAIR_AW'(rec_rdata.len));
                used_next   = used_reg - USED_W'(rec_rdata.len);
                oldest_next = oldest_reg + 1'b1;
                past_next   = past_reg - 1'b1;
                state_next  = S_NEXT;
            end
            S_SCAN:
            begin
                b_re          = scan_issue;
                b_raddr       = scan_addr_reg[WORD_AW-1:0];
                scan_v_next   = scan_issue;
                scan_idx_next = scan_addr_reg[WORD_AW-1:0];
                if (scan_issue)
                begin
                    scan_addr_next = scan_addr_reg + 1'b1;
                end
                if (scan_v_reg && scan_x != 32'd0)
                begin
                    if (phase_reg == P_WRITE)
                    begin
                        p_we      = 1'b1;
                        wptr_next = wptr_reg + 1'b1;
                    end
                    else
                    begin
                        n_next = n_reg + 1'b1;
                    end
                end
                if (!scan_issue && !scan_v_reg)
                begin
                    if (phase_reg == P_WRITE)
                    begin
                        used_next  = used_reg + USED_W'(n_reg);
                        past_next  = past_reg + 1'b1;
                        state_next = S_SWAP;
                    end
                    else
                    begin
                        phase_next = P_FIT;
                        state_next = S_NEXT;
                    end
                end
            end
            S_REC_WR:
            begin
                rec_we         = 1'b1;
                wptr_next      = rec_wdata.start;
                scan_addr_next = '0;
                scan_v_next    = 1'b0;
                phase_next     = P_WRITE;
                state_next     = S_SCAN;
            end
            S_SWAP:
            begin
                sel_next      = ~sel_reg;
                cur_ctr_next  = ctr_in_reg;
                cur_disc_next = disc_in_reg;
                phase_next    = P_FINAL;
                state_next    = S_NEXT;
            end
            S_MOVE_RD:
            begin
                rec_re     = 1'b1;
                rec_raddr  = (op_reg == ACT_REWIND)
                             ? REC_AW'(oldest_reg + past_reg[REC_AW-1:0] - 1'b1)
                             : REC_AW'(oldest_reg + past_reg[REC_AW-1:0]);
                state_next = S_MOVE_META;
            end
            S_MOVE_META:
            begin
                meta_next  = rec_rdata;
                k_next     = '0;
                v1_next    = 1'b0;
                v2_next    = 1'b0;
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                // pair read, then frame read, then xor write back; indices in a
                // record are distinct so the three steps overlap safely
                p_re    = apply_issue;
                v1_next = apply_issue;
                if (apply_issue)
                begin
                    k_next = k_reg + 1'b1;
                end
                b_re      = v1_reg;
                b_raddr   = p_rdata.idx;
                idx2_next = p_rdata.idx;
                val2_next = p_rdata.val;
                v2_next   = v1_reg;
                b_waddr   = idx2_reg;
                b_wdata   = cur_rdata ^ val2_reg;
                if (v2_reg)
                begin
                    if (sel_reg)
                    begin
                        b_we1 = 1'b1;
                    end
                    else
                    begin
                        b_we0 = 1'b1;
                    end
                end
                if (!apply_issue && !v1_reg && !v2_reg)
                begin
                    moved_next = moved_reg + 1'b1;
                    state_next = S_NEXT;
                    if (op_reg == ACT_REWIND)
                    begin
                        cur_ctr_next  = meta_reg.before_ctr;
                        cur_disc_next = meta_reg.before_disc;
                        past_next     = past_reg - 1'b1;
                        fut_next      = fut_reg + 1'b1;
                    end
                    else
                    begin
                        cur_ctr_next  = meta_reg.after_ctr;
                        cur_disc_next = meta_reg.after_disc;
                        past_next     = past_reg + 1'b1;
                        fut_next      = fut_reg - 1'b1;
                    end
                end
            end
            S_DONE:
            begin
                // wait here while the previous result is still unclaimed
                if (!out_valid_reg || result_ready)
                begin
                    out_next = '{read_value: rd_reg, frames_moved: moved_reg,
                                 current_counter: cur_ctr_reg, current_disc: cur_disc_reg,
                                 past_count: past_reg, future_count: fut_reg,
                                 has_current: have_reg};
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= ACT_NONE;
            phase_reg     <= P_DROP;
            sel_reg       <= 1'b0;
            have_reg      <= 1'b0;
            cur_ctr_reg   <= '0;
            cur_disc_reg  <= '0;
            oldest_reg    <= '0;
            past_reg      <= '0;
            fut_reg       <= '0;
            head_reg      <= '0;
            used_reg      <= '0;
            limit_reg     <= CNT_W'(HISTORY_FRAMES);
            n_reg         <= '0;
            scan_addr_reg <= '0;
            scan_v_reg    <= 1'b0;
            wptr_reg      <= '0;
            moved_reg     <= '0;
            pr_reg        <= '0;
            rem_reg       <= '0;
            m_reg         <= '0;
            k_reg         <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            phase_reg     <= phase_next;
            sel_reg       <= sel_next;
            have_reg      <= have_next;
            cur_ctr_reg   <= cur_ctr_next;
            cur_disc_reg  <= cur_disc_next;
            oldest_reg    <= oldest_next;
            past_reg      <= past_next;
            fut_reg       <= fut_next;
            head_reg      <= head_next;
            used_reg      <= used_next;
            limit_reg     <= limit_next;
            n_reg         <= n_next;
            scan_addr_reg <= scan_addr_next;
            scan_v_reg    <= scan_v_next;
            wptr_reg      <= wptr_next;
            moved_reg     <= moved_next;
            pr_reg        <= pr_next;
            rem_reg       <= rem_next;
            m_reg         <= m_next;
            k_reg         <= k_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_in_reg   <= cnt_in_next;
        ctr_in_reg   <= ctr_in_next;
        disc_in_reg  <= disc_in_next;
        scan_idx_reg <= scan_idx_next;
        rd_reg       <= rd_next;
        meta_reg     <= meta_next;
        idx2_reg     <= idx2_next;
        val2_reg     <= val2_next;
        out_reg      <= out_next;
    end

endmodule

FILE: hw/rtl/xdr_check.sv
module xdr_check
    import xdr_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_ready,
    input item_t   item,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result
);

    // a waiting result holds still
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // one transaction in flight at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item taken while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (8'(result.past_count) + 8'(result.future_count))
                         <= 8'(HISTORY_FRAMES))
        else $error("history exceeds ring depth");

    // no history and zero status without a current frame
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.has_current |->
            result.past_count == '0 && result.future_count == '0 &&
            result.current_counter == '0 && result.current_disc == '0)
        else $error("history present without current frame");

endmodule

bind xor_delta_rewind_history_unit xdr_check u_xdr_check (.*);

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import xdr_pkg::*;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_ready;
    item_t   item;
    logic    result_valid;
    logic    result_ready;
    result_t result;

    xor_delta_rewind_history_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // predictor state
    logic [31:0] bank [2][FRAME_WORDS];
    bit          bank_sel;
    logic [9:0]  pr_idx [PAIR_DEPTH];
    logic [31:0] pr_val [PAIR_DEPTH];
    int          pr_head, pr_used;
    logic [63:0] r_bctr [HISTORY_FRAMES];
    logic [63:0] r_actr [HISTORY_FRAMES];
    logic [31:0] r_bdisc [HISTORY_FRAMES];
    logic [31:0] r_adisc [HISTORY_FRAMES];
    int          r_start [HISTORY_FRAMES];
    int          r_len [HISTORY_FRAMES];
    int          oldest, n_past, n_fut;
    logic [63:0] cur_ctr;
    logic [31:0] cur_disc;
    bit          have_cur;
    int          limit;

    // written-word tracking keeps reads and diffs on defined words
    bit          written [2][FRAME_WORDS];

    item_t   pending_items [$];
    result_t expected_status [$];
    int      fail_count;
    bit      stim_done;

    function automatic void wipe_history();
        pr_head = 0; pr_used = 0;
        oldest = 0; n_past = 0; n_fut = 0;
        cur_ctr = '0; cur_disc = '0;
        have_cur = 0;
    endfunction

    function automatic void drop_oldest();
        if (n_past == 0) return;
        pr_head = (pr_head + r_len[oldest]) % PAIR_DEPTH;
        pr_used -= r_len[oldest];
        oldest = (oldest + 1) % HISTORY_FRAMES;
        n_past--;
    endfunction

    function automatic void drop_future();
        int r;
        if (n_fut == 0) return;
        r = (oldest + n_past + n_fut - 1) % HISTORY_FRAMES;
        pr_used -= r_len[r];
        n_fut--;
    endfunction

    function automatic void replay(int r);
        int p;
        for (int k = 0; k < r_len[r]; k++)
        begin
            p = (r_start[r] + k) % PAIR_DEPTH;
            bank[bank_sel][pr_idx[p]] ^= pr_val[p];
        end
    endfunction

    function automatic void record_frame(logic [31:0] disc, logic [63:0] ctr);
        int n, r, w;
        logic [31:0] x;
        if (!have_cur)
        begin
            have_cur = 1; cur_disc = disc; cur_ctr = ctr;
            return;
        end
        while (n_fut > 0) drop_future();
        n = 0;
        for (int i = 0; i < FRAME_WORDS; i++)
            if (bank[0][i] != bank[1][i]) n++;
        while (n_past > 0 && (PAIR_DEPTH - pr_used < n || n_past >= HISTORY_FRAMES))
            drop_oldest();
        if (n <= PAIR_DEPTH - pr_used && n_past < HISTORY_FRAMES)
        begin
            r = (oldest + n_past) % HISTORY_FRAMES;
            w = (pr_head + pr_used) % PAIR_DEPTH;
            r_bctr[r] = cur_ctr; r_actr[r] = ctr;
            r_bdisc[r] = cur_disc; r_adisc[r] = disc;
            r_start[r] = w; r_len[r] = n;
            for (int i = 0; i < FRAME_WORDS; i++)
            begin
                x = bank[0][i] ^ bank[1][i];
                if (x != 0)
                begin
                    pr_idx[w] = 10'(i); pr_val[w] = x;
                    w = (w + 1) % PAIR_DEPTH;
                end
            end
            pr_used += n;
            n_past++;
        end
        bank_sel = !bank_sel;
        cur_ctr = ctr; cur_disc = disc;
        if (n_past + 1 > limit) drop_oldest();
    endfunction

    function automatic void apply_limit(int req);
        int m, total, remove, pr;
        if (req == 0)
        begin
            wipe_history();
            return;
        end
        m = req > HISTORY_FRAMES ? HISTORY_FRAMES : req;
        total = n_past + n_fut + (have_cur ? 1 : 0);
        remove = total - (m < total ? m : total);
        pr = remove < n_past ? remove : n_past;
        remove -= pr;
        repeat (pr) drop_oldest();
        while (remove > 0 && n_fut > 0)
        begin
            drop_future();
            remove--;
        end
        limit = m;
    endfunction

    function automatic result_t predict_status(item_t it);
        result_t res;
        logic [63:0] ctr;
        int moved, r;
        res = '0;
        moved = 0;
        case (it.action)
            ACT_WRITE:
                bank[have_cur ? !bank_sel : bank_sel][it.word_index] = it.word_value;
            ACT_SUBMIT:
            begin
                ctr = it.counter_value;
                if (it.auto_counter) ctr = have_cur ? cur_ctr + 64'd1 : cur_ctr;
                record_frame(it.disc_id, ctr);
            end
            ACT_REWIND:
                while (moved < it.frame_count && n_past > 0)
                begin
                    r = (oldest + n_past - 1) % HISTORY_FRAMES;
                    replay(r);
                    cur_ctr = r_bctr[r]; cur_disc = r_bdisc[r];
                    n_past--; n_fut++; moved++;
                end
            ACT_ADVANCE:
                while (moved < it.frame_count && n_fut > 0)
                begin
                    r = (oldest + n_past) % HISTORY_FRAMES;
                    replay(r);
                    cur_ctr = r_actr[r]; cur_disc = r_adisc[r];
                    n_past++; n_fut--; moved++;
                end
            ACT_READ:
                res.read_value = bank[bank_sel][it.word_index];
            ACT_LIMIT:
                apply_limit(it.frame_count);
            ACT_CLEAR:
                wipe_history();
            default: ;
        endcase
        res.frames_moved    = moved[6:0];
        res.current_counter = cur_ctr;
        res.current_disc    = cur_disc;
        res.past_count      = n_past[6:0];
        res.future_count    = n_fut[6:0];
        res.has_current     = have_cur;
        return res;
    endfunction

    // stimulus side: track which words hold defined data (mirrors routing)
    bit g_have;
    bit g_sel;

    function automatic void queue_item(item_t it);
        bit b;
        case (it.action)
            ACT_WRITE:
            begin
                b = g_have ? !g_sel : g_sel;
                written[b][it.word_index] = 1;
            end
            ACT_SUBMIT:
                if (g_have) g_sel = !g_sel;
                else g_have = 1;
            ACT_LIMIT:
                if (it.frame_count == 0) g_have = 0;
            ACT_CLEAR:
                g_have = 0;
            default: ;
        endcase
        pending_items = {pending_items, it};
    endfunction

    function automatic item_t noise_item(action_t a);
        item_t it;
        it.action        = a;
        it.word_index    = 10'($urandom);
        it.word_value    = $urandom;
        it.disc_id       = $urandom;
        it.counter_value = {$urandom, $urandom};
        it.auto_counter  = 1'($urandom);
        it.frame_count   = 16'($urandom);
        return it;
    endfunction

    // a submit is only safe once both banks are fully defined
    function automatic bit banks_full();
        for (int i = 0; i < FRAME_WORDS; i++)
            if (!written[0][i] || !written[1][i]) return 0;
        return 1;
    endfunction

    function automatic void fill_pending(int changes);
        item_t it;
        bit b;
        b = g_have ? !g_sel : g_sel;
        for (int i = 0; i < FRAME_WORDS; i++)
            if (!written[b][i])
            begin
                it = noise_item(ACT_WRITE);
                it.word_index = 10'(i);
                it.word_value = 0;
                queue_item(it);
            end
        repeat (changes)
        begin
            it = noise_item(ACT_WRITE);
            queue_item(it);
        end
    endfunction

    function automatic void add_read();
        item_t it;
        it = noise_item(ACT_READ);
        while (!written[g_sel][it.word_index]) it.word_index = 10'($urandom);
        queue_item(it);
    endfunction

    initial
    begin
        item_t it;
        int    pick;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        result_ready = 1'b0;
        fail_count = 0;
        stim_done = 0;
        g_have = 0; g_sel = 0;
        bank_sel = 0;
        limit = HISTORY_FRAMES;
        wipe_history();
        foreach (bank[b, i]) bank[b][i] = '0;
        foreach (written[b, i]) written[b][i] = 0;

        // directed: first frame goes to the current bank
        it = noise_item(ACT_WRITE); it.word_index = 0; it.word_value = '0; queue_item(it);
        it = noise_item(ACT_WRITE); it.word_index = 10'h3ff; it.word_value = '1;
        queue_item(it);
        it = noise_item(ACT_READ); it.word_index = 10'h3ff; queue_item(it);
        it = noise_item(ACT_REWIND); it.frame_count = 16'hffff; queue_item(it);
        it = noise_item(ACT_NONE); queue_item(it);
        fill_pending(0);
        it = noise_item(ACT_SUBMIT); it.auto_counter = 1; queue_item(it);
        fill_pending(3);
        it = noise_item(ACT_SUBMIT); it.auto_counter = 0; it.counter_value = '1;
        it.disc_id = '1; queue_item(it);
        fill_pending(64);
        it = noise_item(ACT_SUBMIT); it.auto_counter = 1; queue_item(it);
        it = noise_item(ACT_REWIND); it.frame_count = 1; queue_item(it);
        add_read();
        it = noise_item(ACT_ADVANCE); it.frame_count = 16'hffff; queue_item(it);
        it = noise_item(ACT_LIMIT); it.frame_count = 16'hffff; queue_item(it);
        it = noise_item(ACT_LIMIT); it.frame_count = 1; queue_item(it);
        it = noise_item(ACT_LIMIT); it.frame_count = 0; queue_item(it);
        it = noise_item(ACT_CLEAR); queue_item(it);
        it = noise_item(ACT_LIMIT); it.frame_count = 64; queue_item(it);

        // random: mostly write bursts and submits, some history walking
        for (int n = 0; n < 300; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                queue_item(noise_item(ACT_WRITE));
            else if (pick < 58)
            begin
                if (!g_have || banks_full())
                begin
                    it = noise_item(ACT_SUBMIT);
                    if ($urandom_range(0, 3) == 0) it.auto_counter = 0;
                    queue_item(it);
                end
                else
                    fill_pending(0);
            end
            else if (pick < 68)
            begin
                it = noise_item(ACT_REWIND); it.frame_count = 16'($urandom_range(0, 8));
                if ($urandom_range(0, 15) == 0) it.frame_count = 16'($urandom);
                queue_item(it);
            end
            else if (pick < 78)
            begin
                it = noise_item(ACT_ADVANCE); it.frame_count = 16'($urandom_range(0, 8));
                if ($urandom_range(0, 15) == 0) it.frame_count = 16'($urandom);
                queue_item(it);
            end
            else if (pick < 90)
            begin
                if (written[g_sel][0] || g_have) add_read();
                else queue_item(noise_item(ACT_NONE));
            end
            else if (pick < 96)
            begin
                it = noise_item(ACT_LIMIT);
                it.frame_count = 16'($urandom_range(0, 20) == 0 ? 0 : $urandom_range(1, 70));
                if ($urandom_range(0, 9) == 0) it.frame_count = 16'($urandom);
                queue_item(it);
            end
            else if (pick < 98)
                queue_item(noise_item(ACT_CLEAR));
            else
                queue_item(noise_item(ACT_NONE));
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // driver: bursts of items with random gaps
    int burst_left, gap_left;
    bit item_taken;

    initial
    begin
        burst_left = 0;
        gap_left = 0;
    end

    // handshake seen at the rising edge, used by the driver on the falling edge
    always @(posedge clk)
    begin
        item_taken <= rst_n && item_valid && item_ready;
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!item_valid || item_taken)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    item_valid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    item <= pending_items[0];
                    expected_status = {expected_status, predict_status(pending_items[0])};
                    pending_items.delete(0);
                    item_valid <= 1'b1;
                    if (burst_left <= 0)
                    begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                begin
                    item_valid <= 1'b0;
                    stim_done <= 1;
                end
            end
        end
    end

    // receiver stalls, with one long hold-off early on
    int rcv_cycle;
    initial rcv_cycle = 0;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            rcv_cycle <= rcv_cycle + 1;
            if (rcv_cycle >= 300 && rcv_cycle < 1300)
                result_ready <= 1'b0;
            else if ((rcv_cycle / 200) % 3 == 0)
                result_ready <= 1'b1;
            else
                result_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // monitor: the oldest expectation belongs to the accepted transaction
    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_status.size() == 0)
            begin
                $error("unexpected result transaction");
                fail_count++;
            end
            else
            begin
                exp_r = expected_status[0];
                expected_status.delete(0);
                if (result.read_value !== exp_r.read_value)
                begin
                    $error("read_value exp %h got %h", exp_r.read_value, result.read_value);
                    fail_count++;
                end
                if (result.frames_moved !== exp_r.frames_moved)
                begin
                    $error("frames_moved exp %0d got %0d", exp_r.frames_moved,
                           result.frames_moved);
                    fail_count++;
                end
                if (result.current_counter !== exp_r.current_counter)
                begin
                    $error("current_counter exp %h got %h", exp_r.current_counter,
                           result.current_counter);
                    fail_count++;
                end
                if (result.current_disc !== exp_r.current_disc)
                begin
                    $error("current_disc exp %h got %h", exp_r.current_disc,
                           result.current_disc);
                    fail_count++;
                end
                if (result.past_count !== exp_r.past_count)
                begin
                    $error("past_count exp %0d got %0d", exp_r.past_count, result.past_count);
                    fail_count++;
                end
                if (result.future_count !== exp_r.future_count)
                begin
                    $error("future_count exp %0d got %0d", exp_r.future_count,
                           result.future_count);
                    fail_count++;
                end
                if (result.has_current !== exp_r.has_current)
                begin
                    $error("has_current exp %0d got %0d", exp_r.has_current,
                           result.has_current);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        wait (stim_done && expected_status.size() == 0);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("[xor_delta_rewind_history_unit] OK");
        else
            $display("[xor_delta_rewind_history_unit] ERROR");
        $finish;
    end

    initial
    begin
        #40000000;
        $display("[xor_delta_rewind_history_unit] ERROR");
        $finish;
    end

endmodule
